// ----- hw/rtl/mav_pkg.sv -----
package mav_pkg;

   localparam int unsigned BlockWidth = 128;
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned SqnWidth   = 48;
   localparam int unsigned AmfWidth   = 16;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned RoundCntWidth = 4;
   localparam logic [RoundCntWidth-1:0] LastRound = 4'd10;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_HI    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_LO    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_OP_HI     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_OP_LO     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_OPC_GIVEN = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_MILENAGE  = 3'd5;

   // Milenage output block constants c2, c3, c4
   localparam logic [7:0] C_OUT2 = 8'h01;
   localparam logic [7:0] C_OUT3 = 8'h02;
   localparam logic [7:0] C_OUT4 = 8'h04;

   typedef logic [BlockWidth-1:0] block_type;

   typedef struct packed {
      logic [WordWidth-1:0] rand_hi;
      logic [WordWidth-1:0] rand_lo;
      logic [SqnWidth-1:0]  sqn;
      logic [AmfWidth-1:0]  amf;
   } req_word_type;

   typedef struct packed {
      logic [WordWidth-1:0] mac;
      logic [WordWidth-1:0] xres_hi;
      logic [WordWidth-1:0] xres_lo;
      logic [WordWidth-1:0] ck_hi;
      logic [WordWidth-1:0] ck_lo;
      logic [WordWidth-1:0] ik_hi;
      logic [WordWidth-1:0] ik_lo;
      logic [SqnWidth-1:0]  ak;
      logic [WordWidth-1:0] autn_hi;
      logic [WordWidth-1:0] autn_lo;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_STORE,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PH_OPC,
      PH_TEMP,
      PH_OUT2,
      PH_CK,
      PH_IK,
      PH_MAC
   } phase_type;

   typedef struct packed {
      logic      latch_in;
      logic      aes_load;
      logic      aes_round;
      logic      aes_last;
      logic      store;
      logic      out_load;
      phase_type phase;
   } cmd_type;

   localparam logic [7:0] SBOX_LUT [0:255] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] gf_x2(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic logic [7:0] byte_of(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic block_type key_next(input block_type rk, input logic [7:0] rcon);
      logic [7:0] k [16];
      logic [7:0] n [16];
      block_type  r;
      for (int i = 0; i < 16; i++) k[i] = byte_of(rk, i);
      n[0] = k[0] ^ SBOX_LUT[k[13]] ^ rcon;
      n[1] = k[1] ^ SBOX_LUT[k[14]];
      n[2] = k[2] ^ SBOX_LUT[k[15]];
      n[3] = k[3] ^ SBOX_LUT[k[12]];
      for (int i = 4; i < 16; i++) n[i] = k[i] ^ n[i-4];
      for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = n[i];
      return r;
   endfunction

   // one AES round without the round key addition
   function automatic block_type aes_round(input block_type st, input logic last);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] m [16];
      logic [7:0] all;
      block_type  r;
      for (int i = 0; i < 16; i++) s[i] = SBOX_LUT[byte_of(st, i)];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) t[4*c+i] = s[4*((c+i)%4)+i];
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         for (int i = 0; i < 4; i++)
            m[4*c+i] = t[4*c+i] ^ all ^ gf_x2(t[4*c+i] ^ t[4*c+((i+1)%4)]);
      end
      for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = last ? t[i] : m[i];
      return r;
   endfunction

endpackage

// ----- hw/rtl/mav_if.sv -----
interface mav_req_if;
   logic                  valid;
   logic                  ready;
   mav_pkg::req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mav_rsp_if;
   logic                  valid;
   logic                  ready;
   mav_pkg::rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/mav_ctrl.sv -----
module mav_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             milenage_mode,
   input  logic             opc_given,
   output mav_pkg::cmd_type cmd
);

   mav_pkg::state_type state_ff, state_in;
   mav_pkg::phase_type phase_ff, phase_in;
   logic [mav_pkg::RoundCntWidth-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mav_pkg::ST_IDLE;
         phase_ff     <= mav_pkg::PH_OPC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.phase = phase_ff;
      cmd.aes_last = (cnt_ff == mav_pkg::LastRound);
      unique case (state_ff)
         mav_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               if (!milenage_mode) begin
                  state_in = mav_pkg::ST_FINISH;
               end else begin
                  state_in = mav_pkg::ST_LOAD;
                  phase_in = opc_given ? mav_pkg::PH_TEMP : mav_pkg::PH_OPC;
               end
            end
         end
         mav_pkg::ST_LOAD: begin
            cmd.aes_load = 1'b1;
            cnt_in       = 4'd1;
            state_in     = mav_pkg::ST_ROUND;
         end
         mav_pkg::ST_ROUND: begin
            cmd.aes_round = 1'b1;
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == mav_pkg::LastRound) state_in = mav_pkg::ST_STORE;
         end
         mav_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = mav_pkg::ST_LOAD;
            unique case (phase_ff)
               mav_pkg::PH_OPC:  phase_in = mav_pkg::PH_TEMP;
               mav_pkg::PH_TEMP: phase_in = mav_pkg::PH_OUT2;
               mav_pkg::PH_OUT2: phase_in = mav_pkg::PH_CK;
               mav_pkg::PH_CK:   phase_in = mav_pkg::PH_IK;
               mav_pkg::PH_IK:   phase_in = mav_pkg::PH_MAC;
               mav_pkg::PH_MAC:  state_in = mav_pkg::ST_FINISH;
               default:          state_in = mav_pkg::ST_FINISH;
            endcase
         end
         mav_pkg::ST_FINISH: begin
            // output register free, or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = mav_pkg::ST_IDLE;
            end
         end
         default: state_in = mav_pkg::ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/mav_datapath.sv -----
module mav_datapath (
   input  logic                  clock,
   input  mav_pkg::cmd_type      cmd,
   input  mav_pkg::block_type    key,
   input  mav_pkg::block_type    op,
   input  logic                  milenage_mode,
   input  mav_pkg::req_word_type req_word,
   output mav_pkg::rsp_word_type rsp_word
);

   localparam int unsigned W = mav_pkg::WordWidth;

   mav_pkg::block_type    rand_ff, opc_ff, temp_ff, ck_ff, ik_ff, st_ff, rk_ff;
   mav_pkg::block_type    y, in1, ld_blk, rk_next, res_opc, xt;
   logic [7:0]            rcon_ff;
   logic [mav_pkg::SqnWidth-1:0] sqn_ff, ak_ff, ak_sel;
   logic [mav_pkg::AmfWidth-1:0] amf_ff;
   logic [W-1:0]          xres_ff, mac_ff;
   mav_pkg::rsp_word_type out_ff, out_in;

   always_comb begin
      y   = temp_ff ^ opc_ff;
      in1 = {sqn_ff, amf_ff, sqn_ff, amf_ff} ^ opc_ff;
      unique case (cmd.phase)
         mav_pkg::PH_OPC:  ld_blk = op;
         mav_pkg::PH_TEMP: ld_blk = rand_ff ^ opc_ff;
         mav_pkg::PH_OUT2: ld_blk = y ^ {120'd0, mav_pkg::C_OUT2};
         mav_pkg::PH_CK:   ld_blk = {y[95:0], y[127:96]} ^ {120'd0, mav_pkg::C_OUT3};
         mav_pkg::PH_IK:   ld_blk = {y[63:0], y[127:64]} ^ {120'd0, mav_pkg::C_OUT4};
         mav_pkg::PH_MAC:  ld_blk = {in1[63:0], in1[127:64]} ^ temp_ff;
         default:          ld_blk = op;
      endcase
      rk_next = mav_pkg::key_next(rk_ff, rcon_ff);
      res_opc = st_ff ^ opc_ff;
   end

   // AES core: load adds the first round key, then one round per cycle
   always_ff @(posedge clock) begin
      if (cmd.aes_load) begin
         st_ff   <= ld_blk ^ key;
         rk_ff   <= key;
         rcon_ff <= 8'h01;
      end else if (cmd.aes_round) begin
         st_ff   <= mav_pkg::aes_round(st_ff, cmd.aes_last) ^ rk_next;
         rk_ff   <= rk_next;
         rcon_ff <= mav_pkg::gf_x2(rcon_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         rand_ff <= {req_word.rand_hi, req_word.rand_lo};
         sqn_ff  <= req_word.sqn;
         amf_ff  <= req_word.amf;
         opc_ff  <= op;
      end
      if (cmd.store) begin
         unique case (cmd.phase)
            mav_pkg::PH_OPC:  opc_ff  <= res_opc;
            mav_pkg::PH_TEMP: temp_ff <= st_ff;
            mav_pkg::PH_OUT2: begin
               ak_ff   <= res_opc[127:80];
               xres_ff <= res_opc[63:0];
            end
            mav_pkg::PH_CK:   ck_ff  <= res_opc;
            mav_pkg::PH_IK:   ik_ff  <= res_opc;
            mav_pkg::PH_MAC:  mac_ff <= res_opc[127:64];
            default: ;
         endcase
      end
      if (cmd.out_load) out_ff <= out_in;
   end

   always_comb begin
      xt = key ^ rand_ff;
      if (milenage_mode) begin
         ak_sel         = ak_ff;
         out_in.mac     = mac_ff;
         out_in.xres_hi = xres_ff;
         out_in.xres_lo = '0;
         out_in.ck_hi   = ck_ff[127:64];
         out_in.ck_lo   = ck_ff[63:0];
         out_in.ik_hi   = ik_ff[127:64];
         out_in.ik_lo   = ik_ff[63:0];
      end else begin
         ak_sel         = xt[103:56];
         out_in.mac     = xt[127:64] ^ {sqn_ff, amf_ff};
         out_in.xres_hi = xt[127:64];
         out_in.xres_lo = xt[63:0];
         out_in.ck_hi   = xt[119:56];
         out_in.ck_lo   = {xt[55:0], xt[127:120]};
         out_in.ik_hi   = xt[111:48];
         out_in.ik_lo   = {xt[47:0], xt[127:112]};
      end
      out_in.ak      = ak_sel;
      out_in.autn_hi = {sqn_ff ^ ak_sel, amf_ff};
      out_in.autn_lo = out_in.mac;
   end

   assign rsp_word = out_ff;

endmodule

// ----- hw/rtl/milenage_aka_vector_generator.sv -----
// Milenage mode: six AES passes (load, 10 rounds, store) from accept to result
// with OP configured, five with OPc configured. A new request is accepted only
// once the previous result is loaded, as the single round unit serves all passes.
// Test mode: no AES passes; the result is loaded in FINISH. A result waiting
// on rsp does not block the next accept. Synchronous reset clears control and
// configuration (milenage_mode resets to 1).
module milenage_aka_vector_generator (
   input  logic                                clock,
   input  logic                                reset,
   mav_req_if.sink                             req_chan,
   mav_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [mav_pkg::CsrIdxWidth-1:0]     csr_idx,
   input  logic [mav_pkg::WordWidth-1:0]       csr_wdata
);

   logic [mav_pkg::WordWidth-1:0] key_hi_ff, key_lo_ff, op_hi_ff, op_lo_ff;
   logic opc_given_ff, milenage_ff;
   mav_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         op_hi_ff     <= '0;
         op_lo_ff     <= '0;
         opc_given_ff <= 1'b0;
         milenage_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_idx)
            mav_pkg::CSR_KEY_HI:    key_hi_ff    <= csr_wdata;
            mav_pkg::CSR_KEY_LO:    key_lo_ff    <= csr_wdata;
            mav_pkg::CSR_OP_HI:     op_hi_ff     <= csr_wdata;
            mav_pkg::CSR_OP_LO:     op_lo_ff     <= csr_wdata;
            mav_pkg::CSR_OPC_GIVEN: opc_given_ff <= csr_wdata[0];
            mav_pkg::CSR_MILENAGE:  milenage_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   mav_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .milenage_mode (milenage_ff),
      .opc_given     (opc_given_ff),
      .cmd           (cmd)
   );

   mav_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .key           ({key_hi_ff, key_lo_ff}),
      .op            ({op_hi_ff, op_lo_ff}),
      .milenage_mode (milenage_ff),
      .req_word      (req_chan.payload),
      .rsp_word      (rsp_chan.payload)
   );

endmodule
